[hw/rtl/hmcd_pkg.sv]
// Package for the HTTP message completion detector.
// Holds the word and result types, parser state encodings and character constants.
// No dependencies.
package hmcd_pkg;

    // Default width of every length, sum and byte counter in the parser.
    localparam int unsigned LENGTH_BITS_DEFAULT = 32;

    // Width of the reported body length field.
    localparam int unsigned BODY_LENGTH_W = 32;

    // Character codes used by the matchers.
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_C = 8'h43;

    // Index of the last character of the "Content-Length:" token.
    localparam logic [3:0] TOKEN_LAST = 4'd14;

    // Codes reported on the coding field.
    localparam logic [1:0] CODING_NONE    = 2'd0;
    localparam logic [1:0] CODING_LENGTH  = 2'd1;
    localparam logic [1:0] CODING_CHUNKED = 2'd2;

    // Message phase.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_SIZE_LINE,
        PH_CHUNK_DATA
    } phase_t;

    // Content-Length value parser.
    typedef enum logic [1:0] {
        LP_NOT_FOUND,
        LP_SPACES,
        LP_DIGITS,
        LP_DONE
    } lp_state_t;

    // Chunk size line parser.
    typedef enum logic [1:0] {
        HX_SPACES,
        HX_DIGITS,
        HX_IGNORE
    } hx_state_t;

    // One input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_start;
    } hmcd_word_t;

    // One result word.
    typedef struct packed {
        logic                     complete;
        logic [1:0]               coding;
        logic [BODY_LENGTH_W-1:0] body_length;
    } hmcd_result_t;

    // Decoded hex digit.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Character of the "Content-Length:" token at a given position.
    function automatic logic [7:0] token_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h4c; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3a; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Hex digit decode, either letter case.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.valid = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

[hw/rtl/hmcd_parser.sv]
// Framing parser state and per-byte update for the HTTP message completion detector.
// Depends on hmcd_pkg for types, encodings and character constants.
module hmcd_parser #(
    parameter int unsigned LENGTH_BITS = hmcd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  hmcd_pkg::hmcd_word_t  word,
    output hmcd_pkg::hmcd_result_t result
);

    localparam int unsigned LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam int unsigned BODY_PAD = hmcd_pkg::BODY_LENGTH_W;

    // State registers.
    hmcd_pkg::phase_t    phase_reg, phase_next;
    logic [2:0]          hem_reg, hem_next;
    logic [3:0]          token_reg, token_next;
    hmcd_pkg::lp_state_t lp_reg, lp_next;
    logic [LB-1:0]       declared_reg, declared_next;
    logic [LB-1:0]       body_count_reg, body_count_next;
    logic [LB-1:0]       acc_reg, acc_next;
    hmcd_pkg::hx_state_t hx_reg, hx_next;
    logic                prev_cr_reg, prev_cr_next;
    logic [LB-1:0]       remaining_reg, remaining_next;
    logic [LB-1:0]       data_sum_reg, data_sum_next;
    logic                done_reg, done_next;

    // Arithmetic helpers.
    logic [7:0]          c;
    logic [LB+3:0]       dec_ext;
    logic [LB+3:0]       hex_ext;
    logic [LB:0]         count_inc;
    logic [LB:0]         sum_add;
    logic [LB:0]         rem_add;
    hmcd_pkg::hex_digit_t hd;
    logic [LB+BODY_PAD-1:0] len_ext;

    assign c  = word.data_byte;
    assign hd = hmcd_pkg::hex_decode(c);

    // Next-state logic for one accepted byte.
    always_comb
    begin
        // A start-of-message word sees the reset state.
        if (word.msg_start)
        begin
            phase_next      = hmcd_pkg::PH_HEADER;
            hem_next        = 3'd0;
            token_next      = 4'd0;
            lp_next         = hmcd_pkg::LP_NOT_FOUND;
            declared_next   = '0;
            body_count_next = '0;
            acc_next        = '0;
            hx_next         = hmcd_pkg::HX_SPACES;
            prev_cr_next    = 1'b0;
            remaining_next  = '0;
            data_sum_next   = '0;
            done_next       = 1'b0;
        end
        else
        begin
            phase_next      = phase_reg;
            hem_next        = hem_reg;
            token_next      = token_reg;
            lp_next         = lp_reg;
            declared_next   = declared_reg;
            body_count_next = body_count_reg;
            acc_next        = acc_reg;
            hx_next         = hx_reg;
            prev_cr_next    = prev_cr_reg;
            remaining_next  = remaining_reg;
            data_sum_next   = data_sum_reg;
            done_next       = done_reg;
        end

        dec_ext   = ({4'b0, declared_next} << 3) + ({4'b0, declared_next} << 1)
                    + {{LB{1'b0}}, c[3:0]};
        hex_ext   = {acc_next, hd.value};
        count_inc = {1'b0, body_count_next} + {{LB{1'b0}}, 1'b1};
        sum_add   = '0;
        rem_add   = '0;

        if (!done_next)
        begin
            case (phase_next)
                hmcd_pkg::PH_HEADER:
                begin
                    // Content-Length token and value, first match only.
                    case (lp_next)
                        hmcd_pkg::LP_NOT_FOUND:
                        begin
                            if (c == hmcd_pkg::token_char(token_next))
                                token_next = token_next + 4'd1;
                            else
                                token_next = (c == hmcd_pkg::CHAR_UPPER_C) ? 4'd1 : 4'd0;
                            if (token_next > hmcd_pkg::TOKEN_LAST)
                            begin
                                token_next    = 4'd15;
                                lp_next       = hmcd_pkg::LP_SPACES;
                                declared_next = '0;
                            end
                        end
                        hmcd_pkg::LP_SPACES:
                        begin
                            if (c >= hmcd_pkg::CHAR_ZERO && c <= hmcd_pkg::CHAR_NINE)
                            begin
                                declared_next = {{(LB-4){1'b0}}, c[3:0]};
                                lp_next       = hmcd_pkg::LP_DIGITS;
                            end
                            else if (c != hmcd_pkg::CHAR_SPACE)
                                lp_next = hmcd_pkg::LP_DONE;
                        end
                        hmcd_pkg::LP_DIGITS:
                        begin
                            if (c >= hmcd_pkg::CHAR_ZERO && c <= hmcd_pkg::CHAR_NINE)
                            begin
                                if (dec_ext[LB+3:LB] != 4'd0)
                                    declared_next = LEN_MAX;
                                else
                                    declared_next = dec_ext[LB-1:0];
                            end
                            else
                                lp_next = hmcd_pkg::LP_DONE;
                        end
                        default:
                        begin
                        end
                    endcase

                    // CR LF CR LF matcher.
                    if (hem_next == 3'd0 || hem_next == 3'd2)
                        hem_next = (c == hmcd_pkg::CHAR_CR) ? hem_next + 3'd1 : 3'd0;
                    else if (c == hmcd_pkg::CHAR_LF)
                        hem_next = hem_next + 3'd1;
                    else
                        hem_next = (c == hmcd_pkg::CHAR_CR) ? 3'd1 : 3'd0;

                    // End of header selects the body coding.
                    if (hem_next == 3'd4)
                    begin
                        hem_next = 3'd0;
                        if (lp_next != hmcd_pkg::LP_NOT_FOUND)
                        begin
                            phase_next      = hmcd_pkg::PH_LENGTH;
                            body_count_next = '0;
                            if (declared_next == '0)
                                done_next = 1'b1;
                        end
                        else
                        begin
                            phase_next   = hmcd_pkg::PH_SIZE_LINE;
                            acc_next     = '0;
                            hx_next      = hmcd_pkg::HX_SPACES;
                            prev_cr_next = 1'b0;
                        end
                    end
                end
                hmcd_pkg::PH_LENGTH:
                begin
                    // Count body bytes against the declared length.
                    body_count_next = count_inc[LB] ? LEN_MAX : count_inc[LB-1:0];
                    if (body_count_next >= declared_next)
                        done_next = 1'b1;
                end
                hmcd_pkg::PH_SIZE_LINE:
                begin
                    // Hex size with leading spaces and ignored extensions.
                    case (hx_next)
                        hmcd_pkg::HX_SPACES:
                        begin
                            if (hd.valid)
                            begin
                                acc_next = {{(LB-4){1'b0}}, hd.value};
                                hx_next  = hmcd_pkg::HX_DIGITS;
                            end
                            else if (c != hmcd_pkg::CHAR_SPACE)
                                hx_next = hmcd_pkg::HX_IGNORE;
                        end
                        hmcd_pkg::HX_DIGITS:
                        begin
                            if (hd.valid)
                            begin
                                if (hex_ext[LB+3:LB] != 4'd0)
                                    acc_next = LEN_MAX;
                                else
                                    acc_next = hex_ext[LB-1:0];
                            end
                            else
                                hx_next = hmcd_pkg::HX_IGNORE;
                        end
                        default:
                        begin
                        end
                    endcase

                    // CR LF closes the size line.
                    sum_add = {1'b0, data_sum_next} + {1'b0, acc_next};
                    rem_add = {1'b0, acc_next} + {{(LB-1){1'b0}}, 2'd2};
                    if (c == hmcd_pkg::CHAR_LF && prev_cr_next)
                    begin
                        data_sum_next = sum_add[LB] ? LEN_MAX : sum_add[LB-1:0];
                        if (acc_next == '0)
                            done_next = 1'b1;
                        else
                        begin
                            remaining_next = rem_add[LB] ? LEN_MAX : rem_add[LB-1:0];
                            phase_next     = hmcd_pkg::PH_CHUNK_DATA;
                        end
                        prev_cr_next = 1'b0;
                    end
                    else
                        prev_cr_next = (c == hmcd_pkg::CHAR_CR);
                end
                default:
                begin
                    // Skip chunk data and its trailing CR LF.
                    if (remaining_next != '0)
                        remaining_next = remaining_next - {{(LB-1){1'b0}}, 1'b1};
                    if (remaining_next == '0)
                    begin
                        phase_next   = hmcd_pkg::PH_SIZE_LINE;
                        acc_next     = '0;
                        hx_next      = hmcd_pkg::HX_SPACES;
                        prev_cr_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Result for the byte, taken from the updated state.
    always_comb
    begin
        result.complete = done_next;
        len_ext         = '0;
        case (phase_next)
            hmcd_pkg::PH_HEADER:
            begin
                result.coding = hmcd_pkg::CODING_NONE;
            end
            hmcd_pkg::PH_LENGTH:
            begin
                result.coding = hmcd_pkg::CODING_LENGTH;
                len_ext       = {{BODY_PAD{1'b0}}, declared_next};
            end
            default:
            begin
                result.coding = hmcd_pkg::CODING_CHUNKED;
                len_ext       = {{BODY_PAD{1'b0}}, data_sum_next};
            end
        endcase
        result.body_length = len_ext[BODY_PAD-1:0];
    end

    // State update on each byte taken by the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hmcd_pkg::PH_HEADER;
            hem_reg        <= 3'd0;
            token_reg      <= 4'd0;
            lp_reg         <= hmcd_pkg::LP_NOT_FOUND;
            declared_reg   <= '0;
            body_count_reg <= '0;
            acc_reg        <= '0;
            hx_reg         <= hmcd_pkg::HX_SPACES;
            prev_cr_reg    <= 1'b0;
            remaining_reg  <= '0;
            data_sum_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            hem_reg        <= hem_next;
            token_reg      <= token_next;
            lp_reg         <= lp_next;
            declared_reg   <= declared_next;
            body_count_reg <= body_count_next;
            acc_reg        <= acc_next;
            hx_reg         <= hx_next;
            prev_cr_reg    <= prev_cr_next;
            remaining_reg  <= remaining_next;
            data_sum_reg   <= data_sum_next;
            done_reg       <= done_next;
        end
    end

endmodule

[hw/rtl/http_message_completion_detector_core.sv]
// Top level of the HTTP message completion detector: input word register,
// framing parser and result register. Depends on hmcd_pkg and hmcd_parser.
//
// Usage:
//   The block takes an HTTP/1.1 message one byte per word on the data channel
//   (data_valid, data_ready, data_byte, msg_start) and returns one result word
//   per byte on the result channel (result_valid, result_ready, complete,
//   coding, body_length). Set msg_start on the first byte of every message;
//   it clears the parser before that byte is taken.
//   Path: an accepted byte waits in the input register; its parser update is
//   then loaded into the result register, from which the result word leaves.
//   Throughput: one byte per cycle unless result_ready stalls the result register;
//   the combinational parser update sits between the input and result registers.
//   Stalls: while result_ready is low the result register holds its word and
//   the input register can still take one more byte; data_ready drops only
//   when both registers are full.
//   Reset: rst_n clears both valid flags and puts the parser in the header
//   phase, as if a msg_start byte were due.
module http_message_completion_detector_core #(
    parameter int unsigned LENGTH_BITS = hmcd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        msg_start,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        complete,
    output logic [1:0]  coding,
    output logic [31:0] body_length
);

    logic                   in_valid_reg, in_valid_next;
    hmcd_pkg::hmcd_word_t   in_word_reg;
    logic                   res_valid_reg, res_valid_next;
    hmcd_pkg::hmcd_result_t res_reg;
    hmcd_pkg::hmcd_result_t parser_result;
    logic                   data_accept;
    logic                   res_load;

    // Handshake between the two stages.
    assign res_load      = in_valid_reg && (!res_valid_reg || result_ready);
    assign data_ready    = !in_valid_reg || res_load;
    assign data_accept   = data_valid && data_ready;
    assign in_valid_next = data_accept || (in_valid_reg && !res_load);
    assign res_valid_next = res_load || (res_valid_reg && !result_ready);

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (data_accept)
        begin
            in_word_reg.data_byte <= data_byte;
            in_word_reg.msg_start <= msg_start;
        end
    end

    // Framing parser, updated as its word moves into the result register.
    hmcd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (res_load),
        .word   (in_word_reg),
        .result (parser_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= parser_result;
    end

    assign result_valid = res_valid_reg;
    assign complete     = res_reg.complete;
    assign coding       = res_reg.coding;
    assign body_length  = res_reg.body_length;

    // A delivered word never carries the unused coding.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (coding == hmcd_pkg::CODING_NONE
                          || coding == hmcd_pkg::CODING_LENGTH
                          || coding == hmcd_pkg::CODING_CHUNKED))
        else $error("result word carries an undefined coding");

    // While the header is still open no body length is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && coding == hmcd_pkg::CODING_NONE |-> body_length == 32'd0)
        else $error("body length reported before the header ended");

    // With both registers full and the receiver stalled, input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && in_valid_reg |-> !data_ready)
        else $error("input accepted with both stages full");

    // A finished message stays finished until the next start byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res_valid_reg && res_reg.complete && !in_word_reg.msg_start
        |-> parser_result.complete)
        else $error("completion dropped without a start byte");

endmodule
